// ----- hw/rtl/ss_pkg.sv -----
// Shared types, constants and helpers for the streaming substring search block.
`timescale 1ns / 1ps
`default_nettype none

package ss_pkg;

    localparam int NEEDLE_MAX = 16;
    localparam int BYTE_W     = 8;
    localparam int LEN_W      = 5;
    localparam int CNT_W      = 5;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 64;
    localparam int CODE_W     = 2;
    localparam int IDX_W      = (NEEDLE_MAX > 1) ? $clog2(NEEDLE_MAX) : 1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_NEEDLE_LO   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_NEEDLE_HI   = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_NEEDLE_LEN  = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_IGNORE_CASE = CFG_IDX_W'(3);

    typedef enum logic [CODE_W-1:0] {
        CODE_NOT_FOUND = 2'd0,
        CODE_FOUND     = 2'd1,
        CODE_IDENTICAL = 2'd2
    } match_code_t;

    typedef struct packed {
        logic [2*CFG_DATA_W-1:0] needle;      // byte i in bits 8i+7..8i
        logic [LEN_W-1:0]        pat_len;
        logic                    ignore_case;
    } ss_cfg_t;

    // Lower ASCII 'A'..'Z' when case folding is on
    function automatic logic [BYTE_W-1:0] ss_fold(input logic [BYTE_W-1:0] c,
                                                  input logic icase);
        logic [BYTE_W-1:0] r;
        r = c;
        if (icase && c >= 8'h41 && c <= 8'h5A) begin
            r = c + 8'h20;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/ss_cfg_regs.sv -----
// Configuration register file: needle bytes, needle length and case mode.
`timescale 1ns / 1ps
`default_nettype none

module ss_cfg_regs
    import ss_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  wr_en,
    input  wire logic [CFG_IDX_W-1:0]  wr_index,
    input  wire logic [CFG_DATA_W-1:0] wr_data,
    output ss_cfg_t                    cfg
);

    logic [CFG_DATA_W-1:0] lo_reg;
    logic [CFG_DATA_W-1:0] hi_reg;
    logic [LEN_W-1:0]      len_reg;
    logic                  icase_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lo_reg    <= '0;
            hi_reg    <= '0;
            len_reg   <= '0;
            icase_reg <= 1'b0;
        end else if (wr_en) begin
            unique case (wr_index)
                REG_NEEDLE_LO:   lo_reg    <= wr_data;
                REG_NEEDLE_HI:   hi_reg    <= wr_data;
                REG_NEEDLE_LEN:  len_reg   <= wr_data[LEN_W-1:0];
                REG_IGNORE_CASE: icase_reg <= wr_data[0];
                default: begin
                    // drop writes to unmapped indexes
                end
            endcase
        end
    end

    assign cfg.needle      = {hi_reg, lo_reg};
    assign cfg.pat_len     = len_reg;
    assign cfg.ignore_case = icase_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/ss_matcher.sv -----
// Byte window, saturating count, found flag and parallel needle compare.
`timescale 1ns / 1ps
`default_nettype none

module ss_matcher
    import ss_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              proc,       // consume one registered beat
    input  wire logic [BYTE_W-1:0] text_byte,
    input  wire logic              is_last,
    input  ss_cfg_t                cfg,
    output match_code_t            res_code
);

    localparam logic [CNT_W-1:0] CNT_SAT = CNT_W'(NEEDLE_MAX + 1);
    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(NEEDLE_MAX);

    logic [NEEDLE_MAX-1:0][BYTE_W-1:0] win_reg, win_next, win_new;
    logic [NEEDLE_MAX-1:0][BYTE_W-1:0] win_fold, ndl_fold;
    logic [CNT_W-1:0]                  count_reg, count_next, count_inc;
    logic                              seen_reg, seen_next, seen_upd;
    logic [NEEDLE_MAX-1:0]             hit;          // hit[k]: tail matches length k+1
    logic                              len_ok, cnt_ok, tail_hit;
    logic [IDX_W-1:0]                  len_idx;
    logic [LEN_W-1:0]                  len_m1;

    // Shift in the new byte, newest at entry 0
    always_comb begin
        win_new[0] = text_byte;
        for (int k = 1; k < NEEDLE_MAX; k++) begin
            win_new[k] = win_reg[k-1];
        end
        for (int k = 0; k < NEEDLE_MAX; k++) begin
            win_fold[k] = ss_fold(win_new[k], cfg.ignore_case);
            ndl_fold[k] = ss_fold(cfg.needle[k*BYTE_W +: BYTE_W], cfg.ignore_case);
        end
    end

    // Every candidate length against fixed window and needle positions
    always_comb begin
        for (int l = 0; l < NEEDLE_MAX; l++) begin
            hit[l] = 1'b1;
            for (int j = 0; j <= l; j++) begin
                hit[l] = hit[l] & (win_fold[j] == ndl_fold[l-j]);
            end
        end
    end

    assign count_inc = (count_reg == CNT_SAT) ? CNT_SAT : count_reg + CNT_W'(1);
    assign len_ok    = (cfg.pat_len != '0) && (cfg.pat_len <= LEN_MAX);
    assign cnt_ok    = count_inc >= CNT_W'(cfg.pat_len);
    assign len_m1    = cfg.pat_len - LEN_W'(1);
    assign len_idx   = len_m1[IDX_W-1:0];
    assign tail_hit  = len_ok && cnt_ok && hit[len_idx];
    assign seen_upd  = seen_reg | tail_hit;

    always_comb begin
        priority if (!len_ok || !cnt_ok) begin
            res_code = CODE_NOT_FOUND;
        end else if (count_inc == CNT_W'(cfg.pat_len)) begin
            res_code = seen_upd ? CODE_IDENTICAL : CODE_NOT_FOUND;
        end else begin
            res_code = seen_upd ? CODE_FOUND : CODE_NOT_FOUND;
        end
    end

    always_comb begin
        win_next   = win_reg;
        count_next = count_reg;
        seen_next  = seen_reg;
        if (proc) begin
            if (is_last) begin
                win_next   = '0;
                count_next = '0;
                seen_next  = 1'b0;
            end else begin
                win_next   = win_new;
                count_next = count_inc;
                seen_next  = seen_upd;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_reg   <= '0;
            count_reg <= '0;
            seen_reg  <= 1'b0;
        end else begin
            win_reg   <= win_next;
            count_reg <= count_next;
            seen_reg  <= seen_next;
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_SAT)
        else $error("byte count above saturation");

    a_clear_at_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (proc && is_last) |=> (count_reg == '0) && !seen_reg)
        else $error("stream state not cleared after final beat");

    a_count_moves: assert property (@(posedge aclk) disable iff (!aresetn)
        (proc && !is_last) |=> (count_reg != '0))
        else $error("byte count did not advance");

    a_found_needs_bytes: assert property (@(posedge aclk) disable iff (!aresetn)
        seen_reg |-> (count_reg != '0))
        else $error("found flag set with no bytes seen");

endmodule

`default_nettype wire

// ----- hw/rtl/substring_search_top.sv -----
// Top level of the streaming substring search: input stage, matcher, result stage.
//
//  channel | dir | handshake            | payload
//  --------+-----+----------------------+-------------------------------------
//  s_      | in  | s_tvalid / s_tready  | s_tdata[7:0] text_byte, s_tlast is_last
//  m_      | out | m_tvalid / m_tready  | m_tdata[1:0] match_code
//  cfg_    | in  | cfg_valid / cfg_ready| cfg_index register, cfg_data value
//
// One byte per cycle sustained while the result register can take a final beat;
// the final beat's code is loaded into the result register as that beat is taken.
// The window compare over all needle lengths is one pass of comparators.
// Reset (aresetn low, synchronous) clears the configuration, the window and both
// stage valid bits. A stalled result register only holds back a final beat;
// other beats keep flowing past it.
`timescale 1ns / 1ps
`default_nettype none

module substring_search_top
    import ss_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [7:0]            s_tdata,    // [7:0] text_byte
    input  wire logic                  s_tlast,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [7:0]                 m_tdata,    // [1:0] match_code, [7:2] zero
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    ss_cfg_t           cfg;
    logic              in_vld_reg;
    logic [BYTE_W-1:0] in_byte_reg;
    logic              in_last_reg;
    logic              out_vld_reg;
    match_code_t       out_code_reg;
    match_code_t       res_code;
    logic              out_free, proc, in_fire;

    assign cfg_ready = 1'b1;

    ss_cfg_regs u_cfg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (cfg_valid & cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    // A final beat needs a free result slot; others advance unconditionally
    assign out_free = !out_vld_reg || m_tready;
    assign proc     = in_vld_reg && (!in_last_reg || out_free);
    assign s_tready = !in_vld_reg || proc;
    assign in_fire  = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (in_fire) begin
            in_vld_reg <= 1'b1;
        end else if (proc) begin
            in_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            in_byte_reg <= s_tdata[BYTE_W-1:0];
            in_last_reg <= s_tlast;
        end
    end

    ss_matcher u_match (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .proc      (proc),
        .text_byte (in_byte_reg),
        .is_last   (in_last_reg),
        .cfg       (cfg),
        .res_code  (res_code)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (proc && in_last_reg) begin
            out_vld_reg <= 1'b1;
        end else if (m_tready) begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (proc && in_last_reg) begin
            out_code_reg <= res_code;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {6'b0, out_code_reg};

endmodule

`default_nettype wire
